// ===== rtl/ekdc_pkg.sv =====
`default_nettype none

package ekdc_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 12;

    localparam logic [7:0] KEY_ESC   = 8'h1b;
    localparam logic [7:0] CTRL_MASK = 8'h1f;
    localparam logic [7:0] QUIT_BYTE = 8'h71 & CTRL_MASK;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_5      = 8'h35;
    localparam logic [7:0] CH_6      = 8'h36;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [CFG_BITS-1:0] ROWS_RESET = CFG_BITS'(24);
    localparam logic [CFG_BITS-1:0] COLS_RESET = CFG_BITS'(80);

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        SK_NONE  = 4'd0,
        SK_LEFT  = 4'd1,
        SK_RIGHT = 4'd2,
        SK_UP    = 4'd3,
        SK_DOWN  = 4'd4,
        SK_PGUP  = 4'd5,
        SK_PGDN  = 4'd6,
        SK_HOME  = 4'd7,
        SK_END   = 4'd8,
        SK_DEL   = 4'd9
    } t_skey;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_SEQ   = 2'd2,
        PH_DIGIT = 2'd3
    } t_phase;

    typedef struct packed {
        logic       fire;
        logic [7:0] plain;
        t_skey      sk;
        logic       quit;
    } t_key_evt;

endpackage

`default_nettype wire

// ===== rtl/ekdc_parser.sv =====
`default_nettype none

module ekdc_parser
    import ekdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_op,
    input  wire logic [7:0] i_byte,
    output t_key_evt        o_evt
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_stopped, n_stopped;

    logic       fire;
    logic [7:0] plain;
    t_skey      sk;
    logic       quit;

    function automatic t_skey seq_letter(input logic [7:0] b);
        t_skey k;
        begin
            case (b)
                CH_A:    k = SK_UP;
                CH_B:    k = SK_DOWN;
                CH_C:    k = SK_RIGHT;
                CH_D:    k = SK_LEFT;
                CH_H:    k = SK_HOME;
                CH_F:    k = SK_END;
                default: k = SK_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic t_skey seq_digit(input logic [7:0] d);
        t_skey k;
        begin
            case (d)
                CH_1, CH_7: k = SK_HOME;
                CH_3:       k = SK_DEL;
                CH_4, CH_8: k = SK_END;
                CH_5:       k = SK_PGUP;
                CH_6:       k = SK_PGDN;
                default:    k = SK_NONE;
            endcase
            return k;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_held    <= 8'h00;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_stopped = r_stopped;
        fire      = 1'b0;
        plain     = KEY_ESC;
        sk        = SK_NONE;
        quit      = 1'b0;
        if (i_step && !r_stopped) begin
            if (i_op) begin
                if (r_phase != PH_IDLE) begin
                    fire    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (i_byte == KEY_ESC) begin
                            n_phase = PH_ESC;
                        end else begin
                            fire  = 1'b1;
                            plain = i_byte;
                            if (i_byte == QUIT_BYTE) begin
                                quit      = 1'b1;
                                n_stopped = 1'b1;
                            end
                        end
                    end
                    PH_ESC: begin
                        n_held  = i_byte;
                        n_phase = PH_SEQ;
                    end
                    PH_SEQ: begin
                        if (r_held == CH_LBRACK && i_byte inside {[CH_0:CH_9]}) begin
                            n_held  = i_byte;
                            n_phase = PH_DIGIT;
                        end else begin
                            n_phase = PH_IDLE;
                            fire    = 1'b1;
                            sk      = (r_held == CH_LBRACK) ? seq_letter(i_byte) : SK_NONE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        fire    = 1'b1;
                        sk      = (i_byte == CH_TILDE) ? seq_digit(r_held) : SK_NONE;
                    end
                endcase
            end
        end
        o_evt.fire  = fire;
        o_evt.plain = (sk != SK_NONE) ? 8'h00 : plain;
        o_evt.sk    = sk;
        o_evt.quit  = quit;
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_idle_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_IDLE && o_evt.fire) |-> (o_evt.sk == SK_NONE))
        else $error("special key decoded with no sequence pending");

    a_esc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_stopped && !i_op && r_phase == PH_ESC) |=> (r_phase == PH_SEQ))
        else $error("byte after escape did not advance parser");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !o_evt.fire)
        else $error("key produced while stopped");

endmodule

`default_nettype wire

// ===== rtl/ekdc_cursor.sv =====
`default_nettype none

module ekdc_cursor
    import ekdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_apply,
    input  wire t_skey                 i_sk,
    input  wire logic [CFG_BITS-1:0]   i_rows,
    input  wire logic [CFG_BITS-1:0]   i_cols,
    output logic      [COORD_BITS-1:0] o_col,
    output logic      [COORD_BITS-1:0] o_row
);

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] last_r, last_c;

    function automatic logic [COORD_BITS-1:0] last_pos(input logic [CFG_BITS-1:0] v);
        logic [COORD_BITS:0] lim;
        logic [COORD_BITS:0] s;
        begin
            lim = (COORD_BITS+1)'(1) << COORD_BITS;
            s   = (COORD_BITS+1)'(v);
            if (s == '0) begin
                s = (COORD_BITS+1)'(1);
            end
            if (s > lim) begin
                s = lim;
            end
            return COORD_BITS'(s - (COORD_BITS+1)'(1));
        end
    endfunction

    always_comb begin
        last_r = last_pos(i_rows);
        last_c = last_pos(i_cols);
        n_col  = r_col;
        n_row  = r_row;
        case (i_sk)
            SK_LEFT:  n_col = (r_col != '0) ? r_col - COORD_BITS'(1) : r_col;
            SK_RIGHT: n_col = (r_col >= last_c) ? last_c : r_col + COORD_BITS'(1);
            SK_UP:    n_row = (r_row != '0) ? r_row - COORD_BITS'(1) : r_row;
            SK_DOWN:  n_row = (r_row >= last_r) ? last_r : r_row + COORD_BITS'(1);
            SK_PGUP:  n_row = '0;
            SK_PGDN:  n_row = last_r;
            SK_HOME:  n_col = '0;
            SK_END:   n_col = last_c;
            default:  ;
        endcase
        o_col = n_col;
        o_row = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_apply) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/escape_key_decoder_cursor.sv =====
`default_nettype none

// Terminal key decoder with a screen cursor.
// Input channel: i_in_valid / o_in_stall carry one event per transfer, either a
// received byte (i_op = 0, i_rx_byte) or a read timeout (i_op = 1).
// Output channel: o_out_valid / i_out_stall carry one decoded key per transfer
// with the cursor position after that key. Escape prefixes and sequence bytes
// still in progress, timeouts with no escape pending, and everything after
// Ctrl-Q give no transfer.
// Configuration: i_cfg_we writes i_cfg_data into screen rows (index 0) or
// screen columns (index 1); write only while the block is idle.
// Path: an input transfer is captured in the input register and its key is
// presented from the result register, where it can itself transfer (one input
// register, one result register). Throughput: one event per cycle unless the
// receiver stalls, set by the single decode and clamp stage between the two.
// Reset (synchronous, active low) empties both registers, idles the parser,
// homes the cursor, clears the stopped state and loads a 24 by 80 screen.
// When the receiver stalls, the result holds and the input register fills, then
// o_in_stall rises until the result is taken.
module escape_key_decoder_cursor
    import ekdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [7:0]            i_rx_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [7:0]            o_plain_byte,
    output logic      [3:0]            o_special_key,
    output logic                       o_quit,
    output logic      [COORD_BITS-1:0] o_cursor_col,
    output logic      [COORD_BITS-1:0] o_cursor_row,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]   i_cfg_data
);

    logic                  r_in_valid;
    logic                  r_op;
    logic [7:0]            r_byte;
    logic                  r_out_valid;
    logic [7:0]            r_plain;
    logic [3:0]            r_sk;
    logic                  r_quit;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [CFG_BITS-1:0]   r_rows;
    logic [CFG_BITS-1:0]   r_cols;

    logic                  out_free;
    logic                  step;
    logic                  in_take;
    t_key_evt              evt;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ekdc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .o_evt   (evt)
    );

    ekdc_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (evt.fire),
        .i_sk    (evt.sk),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_col   (n_col),
        .o_row   (n_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= i_op;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (evt.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.fire) begin
            r_plain <= evt.plain;
            r_sk    <= evt.sk;
            r_quit  <= evt.quit;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_plain_byte  = r_plain;
    assign o_special_key = r_sk;
    assign o_quit        = r_quit;
    assign o_cursor_col  = r_col;
    assign o_cursor_row  = r_row;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt.fire |-> out_free)
        else $error("result produced while output register is held");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input item dropped while stalled");

    a_fire_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt.fire |=> r_out_valid)
        else $error("decoded key not presented");

endmodule

`default_nettype wire
